FILE: rtl/core/socc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// socc_pkg
// Shared types, widths and codes of the segment obstacle clearance check.
// ----------------------------------------------------------------------------
package socc_pkg;

    localparam int MAX_OBS   = 16;
    localparam int OBS_IDX_W = 4;
    localparam int CNT_W     = 5;
    localparam int COORD_W   = 14;
    localparam int DIFF_W    = 15;
    localparam int PROD_W    = 30;
    localparam int SQ_W      = 29;
    localparam int CLR_W     = 12;
    localparam int LIM2_W    = 24;
    localparam int ROOT_W    = 30;
    localparam int REACH_W   = 15;
    localparam int REACH2_W  = 30;
    localparam int NUM_W     = 31;
    localparam int NUMSQ_W   = 62;
    localparam int LIMAB_W   = 53;
    localparam int ADDR_W    = 4;
    localparam int DATA_W    = 32;

    typedef enum logic [1:0] {
        ACT_LOAD  = 2'd0,
        ACT_POINT = 2'd1,
        ACT_SEG   = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        REG_COUNT = 2'd0,
        REG_ROBOT = 2'd1,
        REG_BALL  = 2'd2,
        REG_SLACK = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic [CLR_W-1:0] robot;
        logic [CLR_W-1:0] ball;
        logic [CLR_W-1:0] slack;
    } cfg_t;

    typedef struct packed {
        logic capture;
        logic setup;
        logic root_init;
        logic root_step;
        logic limit;
        logic fetch;
        logic square;
        logic sum;
        logic numsq;
        logic next;
        logic post_hit;
        logic post;
    } cmd_t;

    typedef struct packed {
        logic is_point;
        logic seg_zero;
        logic root_last;
        logic scan_end;
        logic hit;
    } stat_t;

endpackage
`default_nettype wire

FILE: rtl/core/socc_ifs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// socc_ifs
// Request and response channels of the clearance check.
// ----------------------------------------------------------------------------
interface socc_req_if;
    logic              valid;
    logic              ready;
    logic [1:0]        action;
    logic [3:0]        slot;
    logic signed [13:0] start_x;
    logic signed [13:0] start_y;
    logic signed [13:0] end_x;
    logic signed [13:0] end_y;
    logic              obstacle_is_ball;

    modport source (output valid, action, slot, start_x, start_y, end_x, end_y,
                    obstacle_is_ball, input ready);
    modport sink (input valid, action, slot, start_x, start_y, end_x, end_y,
                  obstacle_is_ball, output ready);
endinterface

interface socc_rsp_if;
    logic       valid;
    logic       ready;
    logic       blocked;
    logic [3:0] blocking_index;

    modport source (output valid, blocked, blocking_index, input ready);
    modport sink (input valid, blocked, blocking_index, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/socc_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// socc_regs
// APB configuration registers.
// ----------------------------------------------------------------------------
module socc_regs import socc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    output cfg_t                   cfg
);

    cfg_t cfg_reg;
    logic wr;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.count <= '0;
            cfg_reg.robot <= CLR_W'(300);
            cfg_reg.ball  <= CLR_W'(100);
            cfg_reg.slack <= CLR_W'(50);
        end
        else if (wr)
        begin
            case (reg_idx_t'(paddr[3:2]))
                REG_COUNT: cfg_reg.count <= pwdata[CNT_W-1:0];
                REG_ROBOT: cfg_reg.robot <= pwdata[CLR_W-1:0];
                REG_BALL:  cfg_reg.ball  <= pwdata[CLR_W-1:0];
                REG_SLACK: cfg_reg.slack <= pwdata[CLR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx_t'(paddr[3:2]))
            REG_COUNT: prdata = DATA_W'(cfg_reg.count);
            REG_ROBOT: prdata = DATA_W'(cfg_reg.robot);
            REG_BALL:  prdata = DATA_W'(cfg_reg.ball);
            REG_SLACK: prdata = DATA_W'(cfg_reg.slack);
            default:   prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

FILE: rtl/core/socc_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// socc_ctrl
// Sequencer: setup, square root iterations and obstacle scan steps.
// ----------------------------------------------------------------------------
module socc_ctrl import socc_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_ready,
    input  wire logic [1:0] in_action,
    output logic         out_valid,
    input  wire logic    out_ready,
    input  wire stat_t   stat,
    output cmd_t         cmd
);

    typedef enum logic [10:0] {
        S_IDLE   = 11'b00000000001,
        S_SETUP  = 11'b00000000010,
        S_RINIT  = 11'b00000000100,
        S_ROOT   = 11'b00000001000,
        S_LIMIT  = 11'b00000010000,
        S_FETCH  = 11'b00000100000,
        S_SQUARE = 11'b00001000000,
        S_SUM    = 11'b00010000000,
        S_NUMSQ  = 11'b00100000000,
        S_CHECK  = 11'b01000000000,
        S_DONE   = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    if (in_action inside {ACT_POINT, ACT_SEG})
                        state_next = S_SETUP;
                    else
                        state_next = S_DONE;
                end
            end
            S_SETUP:
            begin
                cmd.setup  = 1'b1;
                state_next = stat.is_point ? S_FETCH : S_RINIT;
            end
            S_RINIT:
            begin
                cmd.root_init = 1'b1;
                state_next    = S_ROOT;
            end
            S_ROOT:
            begin
                cmd.root_step = 1'b1;
                if (stat.root_last)
                    state_next = S_LIMIT;
            end
            S_LIMIT:
            begin
                cmd.limit  = 1'b1;
                state_next = stat.seg_zero ? S_DONE : S_FETCH;
            end
            S_FETCH:
            begin
                if (stat.scan_end)
                    state_next = S_DONE;
                else
                begin
                    cmd.fetch  = 1'b1;
                    state_next = S_SQUARE;
                end
            end
            S_SQUARE:
            begin
                cmd.square = 1'b1;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = S_NUMSQ;
            end
            S_NUMSQ:
            begin
                cmd.numsq  = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (stat.hit)
                begin
                    cmd.post_hit = 1'b1;
                    state_next   = S_DONE;
                end
                else
                begin
                    cmd.next   = 1'b1;
                    state_next = S_FETCH;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    cmd.post       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/socc_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// socc_dp
// Obstacle table, line terms, iterative square root and distance tests.
// ----------------------------------------------------------------------------
module socc_dp import socc_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire cmd_t                      cmd,
    output stat_t                          stat,
    input  wire cfg_t                      cfg,
    input  wire logic [1:0]                in_action,
    input  wire logic [OBS_IDX_W-1:0]      in_slot,
    input  wire logic signed [COORD_W-1:0] in_sx,
    input  wire logic signed [COORD_W-1:0] in_sy,
    input  wire logic signed [COORD_W-1:0] in_ex,
    input  wire logic signed [COORD_W-1:0] in_ey,
    input  wire logic                      in_ball,
    output logic                           out_blocked,
    output logic [OBS_IDX_W-1:0]           out_index
);

    logic signed [COORD_W-1:0] obs_x_mem [MAX_OBS];
    logic signed [COORD_W-1:0] obs_y_mem [MAX_OBS];
    logic                      obs_b_mem [MAX_OBS];

    action_t                   act_reg;
    logic signed [COORD_W-1:0] sx_reg, sy_reg, ex_reg, ey_reg;
    logic signed [DIFF_W-1:0]  a_reg, b_reg;
    logic [SQ_W-1:0]           ab2_reg;
    logic [LIM2_W-1:0]         r2_reg, bl2_reg;
    logic [ROOT_W-1:0]         rem_reg, root_reg, bit_reg;
    logic [REACH2_W-1:0]       reach2_reg;
    logic [LIMAB_W-1:0]        rlim_reg, blim_reg;
    logic [CNT_W-1:0]          idx_reg;
    logic signed [DIFF_W-1:0]  d0x_reg, d0y_reg, d1x_reg, d1y_reg;
    logic                      ball_reg;
    logic [SQ_W-1:0]           s0_reg, s1_reg;
    logic signed [PROD_W-1:0]  pa_reg, pb_reg;
    logic [NUM_W-1:0]          num_reg;
    logic                      near_reg, pt_reg;
    logic [NUMSQ_W-1:0]        numsq_reg;
    logic                      res_blk_reg, out_blk_reg;
    logic [OBS_IDX_W-1:0]      res_idx_reg, out_idx_reg;

    logic signed [DIFF_W-1:0]  a_c, b_c;
    logic signed [PROD_W-1:0]  a_sq, b_sq;
    logic [ROOT_W-1:0]         trial;
    logic [REACH_W-1:0]        reach;
    logic [CNT_W-1:0]          n_exam;
    logic signed [NUM_W-1:0]   num_s;
    logic [LIMAB_W-1:0]        lim_sel;

    function automatic logic signed [DIFF_W-1:0] sub_c(
        input logic signed [COORD_W-1:0] p,
        input logic signed [COORD_W-1:0] q
    );
        return DIFF_W'($signed({p[COORD_W-1], p}) - $signed({q[COORD_W-1], q}));
    endfunction

    function automatic logic signed [PROD_W-1:0] mul_s(
        input logic signed [DIFF_W-1:0] p,
        input logic signed [DIFF_W-1:0] q
    );
        logic signed [PROD_W-1:0] pe, qe;
        pe = PROD_W'(p);
        qe = PROD_W'(q);
        return pe * qe;
    endfunction

    assign a_c   = sub_c(sy_reg, ey_reg);
    assign b_c   = sub_c(ex_reg, sx_reg);
    assign a_sq  = mul_s(a_c, a_c);
    assign b_sq  = mul_s(b_c, b_c);
    assign trial = root_reg + bit_reg;
    assign reach = REACH_W'(root_reg) + REACH_W'(cfg.slack);
    assign n_exam = (cfg.count > CNT_W'(MAX_OBS)) ? CNT_W'(MAX_OBS) : cfg.count;
    assign num_s = NUM_W'(pa_reg) + NUM_W'(pb_reg);
    assign lim_sel = ball_reg ? blim_reg : rlim_reg;

    assign stat.is_point  = (act_reg == ACT_POINT);
    assign stat.seg_zero  = (ab2_reg == '0);
    assign stat.root_last = bit_reg[0];
    assign stat.scan_end  = (idx_reg >= n_exam);
    assign stat.hit       = (act_reg == ACT_POINT) ? pt_reg
                          : (near_reg && (numsq_reg <= NUMSQ_W'(lim_sel)));

    assign out_blocked = out_blk_reg;
    assign out_index   = out_idx_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture && (action_t'(in_action) == ACT_LOAD))
        begin
            obs_x_mem[in_slot] <= in_sx;
            obs_y_mem[in_slot] <= in_sy;
            obs_b_mem[in_slot] <= in_ball;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            sx_reg      <= in_sx;
            sy_reg      <= in_sy;
            ex_reg      <= in_ex;
            ey_reg      <= in_ey;
            res_blk_reg <= 1'b0;
            res_idx_reg <= (action_t'(in_action) == ACT_LOAD) ? in_slot : '0;
        end
        if (cmd.setup)
        begin
            a_reg   <= a_c;
            b_reg   <= b_c;
            ab2_reg <= SQ_W'(a_sq) + SQ_W'(b_sq);
            r2_reg  <= LIM2_W'(cfg.robot) * LIM2_W'(cfg.robot);
            bl2_reg <= LIM2_W'(cfg.ball) * LIM2_W'(cfg.ball);
        end
        if (cmd.root_init)
        begin
            rem_reg  <= ROOT_W'(ab2_reg);
            root_reg <= '0;
            bit_reg  <= ROOT_W'(1) << (ROOT_W - 2);
        end
        if (cmd.root_step)
        begin
            if (rem_reg >= trial)
            begin
                rem_reg  <= rem_reg - trial;
                root_reg <= (root_reg >> 1) + bit_reg;
            end
            else
                root_reg <= root_reg >> 1;
            bit_reg <= bit_reg >> 2;
        end
        if (cmd.limit)
        begin
            reach2_reg <= REACH2_W'(reach) * REACH2_W'(reach);
            rlim_reg   <= LIMAB_W'(r2_reg) * LIMAB_W'(ab2_reg);
            blim_reg   <= LIMAB_W'(bl2_reg) * LIMAB_W'(ab2_reg);
        end
        if (cmd.fetch)
        begin
            d0x_reg  <= sub_c(obs_x_mem[idx_reg[OBS_IDX_W-1:0]], sx_reg);
            d0y_reg  <= sub_c(obs_y_mem[idx_reg[OBS_IDX_W-1:0]], sy_reg);
            d1x_reg  <= sub_c(obs_x_mem[idx_reg[OBS_IDX_W-1:0]], ex_reg);
            d1y_reg  <= sub_c(obs_y_mem[idx_reg[OBS_IDX_W-1:0]], ey_reg);
            ball_reg <= obs_b_mem[idx_reg[OBS_IDX_W-1:0]];
        end
        if (cmd.square)
        begin
            s0_reg <= SQ_W'(mul_s(d0x_reg, d0x_reg)) + SQ_W'(mul_s(d0y_reg, d0y_reg));
            s1_reg <= SQ_W'(mul_s(d1x_reg, d1x_reg)) + SQ_W'(mul_s(d1y_reg, d1y_reg));
            pa_reg <= mul_s(a_reg, d0x_reg);
            pb_reg <= mul_s(b_reg, d0y_reg);
        end
        if (cmd.sum)
        begin
            num_reg  <= num_s[NUM_W-1] ? NUM_W'(-num_s) : NUM_W'(num_s);
            near_reg <= (REACH2_W'(s0_reg) < reach2_reg) && (REACH2_W'(s1_reg) < reach2_reg);
            pt_reg   <= (s0_reg < SQ_W'(r2_reg));
        end
        if (cmd.numsq)
            numsq_reg <= NUMSQ_W'(num_reg) * NUMSQ_W'(num_reg);
        if (cmd.post_hit)
        begin
            res_blk_reg <= 1'b1;
            res_idx_reg <= idx_reg[OBS_IDX_W-1:0];
        end
        if (cmd.post)
        begin
            out_blk_reg <= res_blk_reg;
            out_idx_reg <= res_idx_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg <= ACT_NONE;
            idx_reg <= '0;
        end
        else
        begin
            if (cmd.capture)
                act_reg <= action_t'(in_action);
            if (cmd.setup)
                idx_reg <= '0;
            else if (cmd.next)
                idx_reg <= idx_reg + CNT_W'(1);
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/segment_obstacle_clearance_check.sv
`default_nettype none
// ----------------------------------------------------------------------------
// segment_obstacle_clearance_check
// Point and segment clearance test against a 16-entry obstacle table.
// ----------------------------------------------------------------------------
// req carries loads (action 0), point queries (1) and segment queries (2);
// rsp returns one result request per accepted request. The user sets limits
// and the count of examined slots over the APB port while the block is idle;
// not enforced by the block. One request is in work at a time; req.ready
// is high only when the sequencer is idle, from the cycle after a result
// is posted. Steps from acceptance to rsp.valid (receiver ready):
//   load or unused action: capture, then the result is posted
//   point query: setup, then the per-obstacle scan (a hit ends the scan)
//   segment query: setup, the 15-step square root unit, the limits, then
//   the 5-step per-obstacle sequence; a zero-length segment skips the
//   scan after the limits.
// The result sits in an output register; a stalled receiver holds the
// sequencer in its final step until rsp.ready, after which the next request
// is taken. Reset restores the register defaults and empties the pipeline;
// table contents are undefined until loaded.
// ----------------------------------------------------------------------------
module segment_obstacle_clearance_check import socc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    socc_req_if.sink               req,
    socc_rsp_if.source             rsp,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready
);

    cfg_t  cfg;
    cmd_t  cmd;
    stat_t stat;

    socc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    socc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .in_action (req.action),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    socc_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .cfg         (cfg),
        .in_action   (req.action),
        .in_slot     (req.slot),
        .in_sx       (req.start_x),
        .in_sy       (req.start_y),
        .in_ex       (req.end_x),
        .in_ey       (req.end_y),
        .in_ball     (req.obstacle_is_ball),
        .out_blocked (rsp.blocked),
        .out_index   (rsp.blocking_index)
    );

endmodule
`default_nettype wire
